// File: sv/sfc_pkg.sv
package sfc_pkg;

  localparam int PAYLOAD_BYTES = 32;
  localparam int FRAME_BYTES   = PAYLOAD_BYTES + 9;
  localparam int LAST_POS      = FRAME_BYTES - 1;
  localparam int CRC_HI_POS    = PAYLOAD_BYTES + 7;
  localparam int POS_W         = $clog2(FRAME_BYTES);

  localparam int POS_COMMAND = 4;
  localparam int POS_STATUS  = 5;
  localparam int POS_LENGTH  = 6;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_TOP  = 16'h8000;

  localparam logic VERDICT_OK  = 1'b0;
  localparam logic VERDICT_BAD = 1'b1;

  typedef struct packed {
    logic        verdict;
    logic [7:0]  command;
    logic [7:0]  status;
    logic [7:0]  length;
    logic [15:0] crc;
  } result_t;

  // CRC-16/CCITT-FALSE, one byte, msb first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: sv/sfc_frame_core.sv
module sfc_frame_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fire,
  input  logic [7:0]            rx_byte,
  input  logic [31:0]           sync_word,
  output logic                  res_valid,
  output sfc_pkg::result_t      res
);

  logic [sfc_pkg::POS_W-1:0] pos, pos_next;
  logic [15:0]               crc, crc_next;
  logic                      matched, matched_next;
  logic [7:0]                held_command;
  logic [7:0]                held_status;
  logic [7:0]                held_length;
  logic [7:0]                crc_hi;
  logic [7:0]                want;
  logic                      at_last;

  localparam logic [sfc_pkg::POS_W-1:0] LAST   = sfc_pkg::POS_W'(sfc_pkg::LAST_POS);
  localparam logic [sfc_pkg::POS_W-1:0] CRC_HI = sfc_pkg::POS_W'(sfc_pkg::CRC_HI_POS);
  localparam logic [sfc_pkg::POS_W-1:0] P_CMD  = sfc_pkg::POS_W'(sfc_pkg::POS_COMMAND);
  localparam logic [sfc_pkg::POS_W-1:0] P_STS  = sfc_pkg::POS_W'(sfc_pkg::POS_STATUS);
  localparam logic [sfc_pkg::POS_W-1:0] P_LEN  = sfc_pkg::POS_W'(sfc_pkg::POS_LENGTH);

  always_comb begin
    case (pos[1:0])
      2'd0:    want = sync_word[31:24];
      2'd1:    want = sync_word[23:16];
      2'd2:    want = sync_word[15:8];
      default: want = sync_word[7:0];
    endcase
  end

  assign at_last = (pos >= LAST);

  always_comb begin
    pos_next     = pos;
    crc_next     = crc;
    matched_next = matched;
    if (fire) begin
      if (at_last) begin
        pos_next     = '0;
        crc_next     = sfc_pkg::CRC_INIT;
        matched_next = 1'b1;
      end else begin
        pos_next = pos + 1'b1;
        if (pos < P_CMD) begin
          if (rx_byte != want) begin
            matched_next = 1'b0;
          end
        end else if (pos < CRC_HI) begin
          crc_next = sfc_pkg::crc_feed(crc, rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      crc     <= sfc_pkg::CRC_INIT;
      matched <= 1'b1;
    end else begin
      pos     <= pos_next;
      crc     <= crc_next;
      matched <= matched_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_command <= '0;
      held_status  <= '0;
      held_length  <= '0;
      crc_hi       <= '0;
    end else if (fire) begin
      if (pos == P_CMD) held_command <= rx_byte;
      if (pos == P_STS) held_status  <= rx_byte;
      if (pos == P_LEN) held_length  <= rx_byte;
      if (pos == CRC_HI) crc_hi      <= rx_byte;
    end
  end

  assign res_valid   = fire && at_last && matched;
  assign res.crc     = {crc_hi, rx_byte};
  assign res.verdict = ({crc_hi, rx_byte} != crc) ? sfc_pkg::VERDICT_BAD : sfc_pkg::VERDICT_OK;
  assign res.command = held_command;
  assign res.status  = held_status;
  assign res.length  = held_length;

  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= LAST)
    else $error("frame position beyond last byte");

  a_res_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (fire && pos == LAST && matched))
    else $error("result outside frame end");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    (fire && pos == LAST) |=> (pos == '0 && crc == sfc_pkg::CRC_INIT && matched))
    else $error("frame state not restarted");

  a_crc_hold: assert property (@(posedge clk) disable iff (rst)
    (!fire) |=> ($stable(pos) && $stable(crc)))
    else $error("frame state moved without an item");

endmodule

// File: sv/sfc_out_reg.sv
module sfc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  sfc_pkg::result_t res,
  output logic             out_free,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [39:0]      m_axis_tdata,
  output logic             m_axis_tuser
);

  sfc_pkg::result_t held;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && out_free) begin
      held <= res;
    end
  end

  assign m_axis_tdata = {held.crc, held.length, held.status, held.command};
  assign m_axis_tuser = held.verdict;

endmodule

// File: sv/sync_frame_crc_checker.sv
// Channel   Dir  Payload
// s_axis    in   tdata[7:0] rx_byte
// m_axis    out  tdata command, status, length, received_crc; tuser verdict
// sync_word in   write enable + 32-bit data, first start byte in [31:24]
//
// One byte per cycle while m_axis does not stall. A byte is held in the input
// register, the CRC update and frame counter act on it, and a verdict lands in
// the output register at the next edge: m_axis_tvalid rises from the output
// register once the last byte of a matched frame has passed the input register.
// rst is synchronous and restarts the frame count at the first start byte.
// A stall on m_axis holds the input register, which then holds s_axis.
module sync_frame_crc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        sync_word_we,
  input  logic [31:0] sync_word_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [7:0] command, [15:8] status, [23:16] length,
                                      // [39:24] received_crc
  output logic        m_axis_tuser    // [0] verdict: 0 ok, 1 CRC mismatch
);

  logic             s1_valid;
  logic [7:0]       s1_byte;
  logic [31:0]      sync_word;
  logic             out_free;
  logic             fire;
  logic             res_valid;
  sfc_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= '0;
    end else if (sync_word_we) begin
      sync_word <= sync_word_wdata;
    end
  end

  // advance the held byte whenever the result register can take a result
  assign fire          = s1_valid && out_free;
  assign s_axis_tready = !s1_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      s1_byte <= s_axis_tdata;
    end
  end

  sfc_frame_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .rx_byte   (s1_byte),
    .sync_word (sync_word),
    .res_valid (res_valid),
    .res       (res)
  );

  sfc_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .load          (res_valid),
    .res           (res),
    .out_free      (out_free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// File: tb/sv/frame_verdict_checker.sv
`timescale 1ns / 100ps

module frame_verdict_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        sync_word_we,
  input  logic [31:0] sync_word_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [39:0] m_axis_tdata,
  input  logic        m_axis_tuser,
  output int          errors,
  output int          pending
);

  logic [31:0]      sync_word;
  logic [6:0]       frame_pos;
  logic [15:0]      crc_acc;
  logic             sync_ok;
  logic [7:0]       cmd_q;
  logic [7:0]       status_q;
  logic [7:0]       length_q;
  logic [7:0]       crc_hi_q;
  sfc_pkg::result_t expected_verdicts[$];

  // Bit-serial CRC-16/CCITT-FALSE step over one byte, msb first.
  function automatic logic [15:0] ccitt_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] acc;
    logic        fb;
    acc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      fb  = acc[15] ^ data[i];
      acc = {acc[14:0], 1'b0};
      if (fb) begin
        acc = acc ^ sfc_pkg::CRC_POLY;
      end
    end
    return acc;
  endfunction

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic track_frame_byte(input logic [7:0] b);
    sfc_pkg::result_t r;
    if (frame_pos < sfc_pkg::POS_COMMAND) begin
      // Each start byte is compared against the sync word as it stands now.
      if (b != sync_word[31 - 8 * frame_pos -: 8]) begin
        sync_ok = 1'b0;
      end
    end else if (frame_pos < sfc_pkg::CRC_HI_POS) begin
      if (frame_pos == sfc_pkg::POS_COMMAND) begin
        cmd_q = b;
      end else if (frame_pos == sfc_pkg::POS_STATUS) begin
        status_q = b;
      end else if (frame_pos == sfc_pkg::POS_LENGTH) begin
        length_q = b;
      end
      crc_acc = ccitt_byte(crc_acc, b);
    end else if (frame_pos == sfc_pkg::CRC_HI_POS) begin
      crc_hi_q = b;
    end

    if (frame_pos >= sfc_pkg::LAST_POS) begin
      if (sync_ok) begin
        r.crc     = {crc_hi_q, b};
        r.verdict = (r.crc != crc_acc) ? sfc_pkg::VERDICT_BAD : sfc_pkg::VERDICT_OK;
        r.command = cmd_q;
        r.status  = status_q;
        r.length  = length_q;
        expected_verdicts.push_back(r);
      end
      frame_pos = '0;
      crc_acc   = sfc_pkg::CRC_INIT;
      sync_ok   = 1'b1;
    end else begin
      frame_pos = frame_pos + 7'd1;
    end
  endtask

  always @(posedge clk) begin
    sfc_pkg::result_t exp_r;
    if (rst) begin
      errors    = 0;
      sync_word = '0;
      frame_pos = '0;
      crc_acc   = sfc_pkg::CRC_INIT;
      sync_ok   = 1'b1;
      cmd_q     = '0;
      status_q  = '0;
      length_q  = '0;
      crc_hi_q  = '0;
      expected_verdicts.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_frame_byte(s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          report($sformatf("verdict item %0h/%0h with none expected",
                           m_axis_tuser, m_axis_tdata));
        end else begin
          exp_r = expected_verdicts.pop_front();
          if (m_axis_tuser !== exp_r.verdict)
            report($sformatf("verdict got %0h exp %0h", m_axis_tuser, exp_r.verdict));
          if (m_axis_tdata[7:0] !== exp_r.command)
            report($sformatf("command got %0h exp %0h", m_axis_tdata[7:0], exp_r.command));
          if (m_axis_tdata[15:8] !== exp_r.status)
            report($sformatf("status got %0h exp %0h", m_axis_tdata[15:8], exp_r.status));
          if (m_axis_tdata[23:16] !== exp_r.length)
            report($sformatf("length got %0h exp %0h", m_axis_tdata[23:16], exp_r.length));
          if (m_axis_tdata[39:24] !== exp_r.crc)
            report($sformatf("crc got %0h exp %0h", m_axis_tdata[39:24], exp_r.crc));
        end
      end
      if (sync_word_we) begin
        sync_word = sync_word_wdata;
      end
    end
    pending <= expected_verdicts.size();
  end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {FILL_ZERO, FILL_ONES, FILL_RANDOM} fill_t;

  logic        clk;
  logic        rst;
  logic        sync_word_we;
  logic [31:0] sync_word_wdata;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tuser;

  int          errors;
  int          pending;
  int          stall_cycles;
  int          stream_pos;
  bit          idle_en;
  logic [31:0] cur_sync;

  sync_frame_crc_checker DUT (
    .clk             (clk),
    .rst             (rst),
    .sync_word_we    (sync_word_we),
    .sync_word_wdata (sync_word_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser)
  );

  frame_verdict_checker u_chk (
    .clk             (clk),
    .rst             (rst),
    .sync_word_we    (sync_word_we),
    .sync_word_wdata (sync_word_wdata),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tuser    (m_axis_tuser),
    .errors          (errors),
    .pending         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Result side: random stall bursts while idling is on.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_en && $urandom_range(0, 2) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(input logic [7:0] b);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 8)) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    stream_pos = (stream_pos == sfc_pkg::LAST_POS) ? 0 : stream_pos + 1;
  endtask

  // Build a frame on the current sync word, send it from the current stream
  // position up to byte index upto.
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] st,
                            input logic [7:0] len, input fill_t fill,
                            input logic [15:0] crc_flip, input int bad_sync_at,
                            input int upto);
    logic [7:0]  frm [sfc_pkg::FRAME_BYTES];
    logic [15:0] crc;
    for (int i = 0; i < sfc_pkg::POS_COMMAND; i++) begin
      frm[i] = cur_sync[31 - 8 * i -: 8];
    end
    if (bad_sync_at >= 0) begin
      frm[bad_sync_at] = frm[bad_sync_at] ^ 8'($urandom_range(1, 255));
    end
    frm[sfc_pkg::POS_COMMAND] = cmd;
    frm[sfc_pkg::POS_STATUS]  = st;
    frm[sfc_pkg::POS_LENGTH]  = len;
    for (int i = sfc_pkg::POS_LENGTH + 1; i < sfc_pkg::CRC_HI_POS; i++) begin
      case (fill)
        FILL_ZERO: frm[i] = 8'h00;
        FILL_ONES: frm[i] = 8'hFF;
        default:   frm[i] = 8'($urandom);
      endcase
    end
    crc = sfc_pkg::CRC_INIT;
    for (int i = sfc_pkg::POS_COMMAND; i < sfc_pkg::CRC_HI_POS; i++) begin
      crc = sfc_pkg::crc_feed(crc, frm[i]);
    end
    crc = crc ^ crc_flip;
    frm[sfc_pkg::CRC_HI_POS] = crc[15:8];
    frm[sfc_pkg::LAST_POS]   = crc[7:0];
    for (int i = stream_pos; i <= upto; i++) begin
      send_byte(frm[i]);
    end
  endtask

  task automatic send_random_frame();
    int    kind;
    fill_t fill;
    kind = $urandom_range(0, 19);
    case ($urandom_range(0, 9))
      0:       fill = FILL_ZERO;
      1:       fill = FILL_ONES;
      default: fill = FILL_RANDOM;
    endcase
    if (kind < 12) begin
      send_frame(pick_byte(), pick_byte(), pick_byte(), fill, 16'h0000, -1,
                 sfc_pkg::LAST_POS);
    end else if (kind < 16) begin
      send_frame(pick_byte(), pick_byte(), pick_byte(), fill,
                 16'($urandom_range(1, 65535)), -1, sfc_pkg::LAST_POS);
    end else if (kind < 19) begin
      send_frame(pick_byte(), pick_byte(), pick_byte(), fill, 16'h0000,
                 $urandom_range(0, 3), sfc_pkg::LAST_POS);
    end else begin
      // line noise: random bytes up to the end of the current frame
      while (stream_pos != 0 || kind != 0) begin
        kind = 0;
        send_byte(8'($urandom));
      end
    end
  endtask

  // Write only with nothing in flight: drain results, then let the pipeline settle.
  task automatic write_sync(input logic [31:0] word);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    sync_word_we    <= 1'b1;
    sync_word_wdata <= word;
    @(negedge clk);
    sync_word_we <= 1'b0;
    cur_sync = word;
  endtask

  initial begin
    logic [31:0] word;
    rst             = 1'b1;
    sync_word_we    = 1'b0;
    sync_word_wdata = '0;
    s_axis_tvalid   = 1'b0;
    s_axis_tdata    = '0;
    stream_pos      = 0;
    idle_en         = 1'b1;
    cur_sync        = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed frames on the reset sync word
    send_frame(8'h00, 8'h00, 8'h00, FILL_ZERO, 16'h0000, -1, sfc_pkg::LAST_POS);
    send_frame(8'hFF, 8'hFF, 8'hFF, FILL_ONES, 16'h0000, -1, sfc_pkg::LAST_POS);
    send_frame(pick_byte(), pick_byte(), pick_byte(), FILL_RANDOM, 16'hFFFF, -1,
               sfc_pkg::LAST_POS);
    send_frame(pick_byte(), pick_byte(), pick_byte(), FILL_RANDOM, 16'h0001, -1,
               sfc_pkg::LAST_POS);
    send_frame(pick_byte(), pick_byte(), pick_byte(), FILL_RANDOM, 16'h8000, -1,
               sfc_pkg::LAST_POS);
    for (int j = 0; j < sfc_pkg::POS_COMMAND; j++) begin
      send_frame(pick_byte(), pick_byte(), pick_byte(), FILL_RANDOM, 16'h0000, j,
                 sfc_pkg::LAST_POS);
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) begin
        idle_en = 1'b0;
      end
      case (ph)
        0:       word = 32'hFFFF_FFFF;
        3:       word = 32'h0000_0000;
        default: word = $urandom;
      endcase
      write_sync(word);
      repeat (5) send_random_frame();
      // leave a frame open across the next sync word change
      if (ph < 5 && $urandom_range(0, 1) == 1) begin
        send_frame(pick_byte(), pick_byte(), pick_byte(), FILL_RANDOM, 16'h0000, -1,
                   $urandom_range(0, 3));
      end
    end
    if (stream_pos != 0) begin
      send_frame(pick_byte(), pick_byte(), pick_byte(), FILL_RANDOM, 16'h0000, -1,
                 sfc_pkg::LAST_POS);
    end

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
